// File: rtl/i2da_pkg.sv
`default_nettype none
package i2da_pkg;

  // field widths
  localparam int BIN_W      = 32;
  localparam int MIN_W      = 5;
  localparam int LEN_W      = 6;
  localparam int CHAR_W     = 8;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int CNT_W      = $clog2(BIN_W);
  localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);

  // default text capacity
  localparam int MAX_CHARS_DEF = 32;

  // ascii codes
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_PREP,
    ST_EMIT
  } i2da_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic shift;
    logic prep;
    logic emit;
  } i2da_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic at_last;
  } i2da_sts_t;

  // double dabble: add 3 to every bcd digit of 5 or more
  function automatic logic [BCD_W-1:0] dabble_adjust(input logic [BCD_W-1:0] bcd);
    logic [BCD_W-1:0] res;
    res = bcd;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// File: rtl/i2da_ctrl.sv
`default_nettype none
module i2da_ctrl
  import i2da_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire i2da_sts_t sts,
  output i2da_cmd_t      cmd
);

  i2da_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (cnt_r == CNT_W'(BIN_W - 1)) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free && sts.at_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CONV: cmd.shift = 1'b1;
      ST_PREP: cmd.prep  = 1'b1;
      ST_EMIT: cmd.emit  = 1'b1;
      default: cmd = '0;
    endcase
  end

  // shift counter
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      cnt_nxt = '0;
    end else if (cmd.shift) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/i2da_dpath.sv
`default_nettype none
module i2da_dpath
  import i2da_pkg::*;
#(
  parameter int MAX_CHARS = MAX_CHARS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire i2da_cmd_t         cmd,
  output i2da_sts_t              sts,
  input  wire logic [BIN_W-1:0]  in_value,
  input  wire logic [MIN_W-1:0]  in_min_digits,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [CHAR_W-1:0]      out_char_out,
  output logic                   out_last,
  output logic [LEN_W-1:0]       out_text_length
);

  // text never exceeds sign plus 31 digits, so capacity above 32 never cuts
  localparam int CAP = (MAX_CHARS > 32) ? 32 : MAX_CHARS;

  logic [BIN_W-1:0]  bin_r, bin_nxt;
  logic [BCD_W-1:0]  bcd_r, bcd_nxt;
  logic              neg_r, neg_nxt;
  logic [MIN_W-1:0]  min_r, min_nxt;
  logic [LEN_W-1:0]  nd_r, nd_nxt;
  logic [LEN_W-1:0]  pd_r, pd_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  pos_r, pos_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;
  logic [LEN_W-1:0]  out_len_r, out_len_nxt;

  logic              out_free;
  logic              step;
  logic [BCD_W-1:0]  bcd_adj;
  logic [LEN_W-1:0]  nd_c, pd_c, room_c, min_ext, total_c;
  logic [CHAR_W-1:0] char_c;

  function automatic logic [3:0] digit_at(input logic [BCD_W-1:0] bcd,
                                          input logic [DIG_IDX_W-1:0] idx);
    logic [3:0] d;
    d = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (idx == DIG_IDX_W'(i)) begin
        d = bcd[4*i +: 4];
      end
    end
    return d;
  endfunction

  assign out_free = !out_valid_r || out_ready;
  assign step     = cmd.emit && out_free;
  assign bcd_adj  = dabble_adjust(bcd_r);

  // digit count, padding and total length from the finished bcd word
  always_comb begin
    nd_c = LEN_W'(1);
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] != 4'd0) begin
        nd_c = LEN_W'(i + 1);
      end
    end
    min_ext = LEN_W'(min_r);
    room_c  = LEN_W'(CAP) - LEN_W'(neg_r);
    pd_c    = (min_ext > nd_c) ? min_ext : nd_c;
    if (pd_c > room_c) begin
      pd_c = (room_c > nd_c) ? room_c : nd_c;
    end
    total_c = pd_c + LEN_W'(neg_r);
  end

  // character at the current position, counted from the right
  always_comb begin
    if (neg_r && (pos_r == pd_r)) begin
      char_c = CH_MINUS;
    end else if (pos_r < nd_r) begin
      char_c = CH_ZERO + CHAR_W'(digit_at(bcd_r, pos_r[DIG_IDX_W-1:0]));
    end else begin
      char_c = CH_ZERO;
    end
  end

  // conversion registers
  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    neg_nxt = neg_r;
    min_nxt = min_r;
    nd_nxt  = nd_r;
    pd_nxt  = pd_r;
    len_nxt = len_r;
    pos_nxt = pos_r;
    if (cmd.load) begin
      neg_nxt = in_value[BIN_W-1];
      bin_nxt = in_value[BIN_W-1] ? (~in_value + BIN_W'(1)) : in_value;
      bcd_nxt = '0;
      min_nxt = in_min_digits;
    end else if (cmd.shift) begin
      bin_nxt = {bin_r[BIN_W-2:0], 1'b0};
      bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[BIN_W-1]};
    end else if (cmd.prep) begin
      nd_nxt  = nd_c;
      pd_nxt  = pd_c;
      len_nxt = total_c;
      pos_nxt = total_c - LEN_W'(1);
    end else if (step) begin
      pos_nxt = pos_r - LEN_W'(1);
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_len_nxt   = out_len_r;
    if (step) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = char_c;
      out_last_nxt  = (pos_r == '0);
      out_len_nxt   = (pos_r == '0) ? len_r : '0;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    neg_r      <= neg_nxt;
    min_r      <= min_nxt;
    nd_r       <= nd_nxt;
    pd_r       <= pd_nxt;
    len_r      <= len_nxt;
    pos_r      <= pos_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_len_r  <= out_len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign sts.out_free   = out_free;
  assign sts.at_last    = (pos_r == '0);
  assign out_valid       = out_valid_r;
  assign out_char_out    = out_char_r;
  assign out_last        = out_last_r;
  assign out_text_length = out_len_r;

endmodule
`default_nettype wire

// File: rtl/int_to_decimal_ascii.sv
`default_nettype none
// channel | direction | handshake            | payload
// in_     | input     | in_valid / in_ready   | in_value[31:0], in_min_digits[4:0]
// out_    | output    | out_valid / out_ready | out_char_out[7:0], out_last, out_text_length[5:0]
//
// one number is accepted, then takes one double dabble shift per input bit (one bit per cycle),
// then the text is sized, then one character per cycle while the output is not stalled.
// the output register lets a stalled character wait while the next number is taken.
// rst_n is synchronous and clears the controller state and the output valid.
// a stalled output holds the character and pauses the emit sequence.
module int_to_decimal_ascii
  import i2da_pkg::*;
#(
  parameter int MAX_CHARS = MAX_CHARS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BIN_W-1:0]  in_value,
  input  wire logic [MIN_W-1:0]  in_min_digits,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [CHAR_W-1:0]      out_char_out,
  output logic                   out_last,
  output logic [LEN_W-1:0]       out_text_length
);

  i2da_cmd_t cmd;
  i2da_sts_t sts;

  // sequencer
  i2da_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // conversion and character output
  i2da_dpath #(
    .MAX_CHARS (MAX_CHARS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_value        (in_value),
    .in_min_digits   (in_min_digits),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char_out    (out_char_out),
    .out_last        (out_last),
    .out_text_length (out_text_length)
  );

endmodule
`default_nettype wire
